FILE: sv/cobs_pkg.sv
// Package for the cartridge outer bank scrambler: request codes, register
// indexes and the scramble, command permute and protection tables.
// No dependencies.
`default_nettype none

package cobs_pkg;

  typedef enum logic [1:0] {
    REQ_CPU_WRITE = 2'd0,
    REQ_CPU_READ  = 2'd1,
    REQ_PRG_XLATE = 2'd2,
    REQ_CHR_XLATE = 2'd3
  } req_type_t;

  localparam logic [1:0] REG_WIDE_SUBMAPPER = 2'd0;
  localparam logic [1:0] REG_DIP_ENABLE     = 2'd1;
  localparam logic [1:0] REG_DIP_SETTING    = 2'd2;

  localparam logic [2:0] OREG_MODE     = 3'd0;
  localparam logic [2:0] OREG_BANK     = 3'd1;
  localparam logic [2:0] OREG_PROTECT  = 3'd2;
  localparam logic [2:0] OREG_SCRAMBLE = 3'd7;

  localparam logic [15:0] OUTER_LO  = 16'h5000;
  localparam logic [15:0] OUTER_HI  = 16'h5FFF;
  localparam logic [15:0] MMC3_CMD  = 16'h8000;
  localparam logic [15:0] MMC3_BASE = 16'h8000;

  localparam logic [7:0] MODE_RESET     = 8'h00;
  localparam logic [7:0] BANK_RESET     = 8'h03;
  localparam logic [2:0] PROTECT_RESET  = 3'd7;
  localparam logic [2:0] SCRAMBLE_RESET = 3'd4;

  // Flags of one result beat, highest bit first in out_tuser.
  typedef struct packed {
    logic read_valid;
    logic refresh_banks;
    logic fwd_valid;
  } res_flags_t;

  // MMC3 register address for a scramble row and a slot {addr[14:13], addr[0]}.
  function automatic logic [15:0] scramble_addr(input logic [2:0] sel,
                                                input logic [2:0] idx);
    logic [15:0] a;
    a = 16'h8000;
    case (sel)
      3'd1: begin
        case (idx)
          3'd0: a = 16'hA001;
          3'd1: a = 16'hA000;
          3'd2: a = 16'h8000;
          3'd3: a = 16'hC000;
          3'd4: a = 16'h8001;
          3'd5: a = 16'hC001;
          3'd6: a = 16'hE000;
          default: a = 16'hE001;
        endcase
      end
      3'd3: begin
        case (idx)
          3'd0: a = 16'hC001;
          3'd1: a = 16'h8000;
          3'd2: a = 16'h8001;
          3'd3: a = 16'hA000;
          3'd4: a = 16'hA001;
          3'd5: a = 16'hE001;
          3'd6: a = 16'hE000;
          default: a = 16'hC000;
        endcase
      end
      3'd4: begin
        case (idx)
          3'd0: a = 16'hA001;
          3'd1: a = 16'h8001;
          3'd2: a = 16'h8000;
          3'd3: a = 16'hC000;
          3'd4: a = 16'hA000;
          3'd5: a = 16'hC001;
          3'd6: a = 16'hE000;
          default: a = 16'hE001;
        endcase
      end
      default: begin
        // Unscrambled rows: even slots at the register base, odd ones at base+1.
        a = MMC3_BASE | {1'b0, idx[2:1], 13'h0000} | {15'h0000, idx[0]};
      end
    endcase
    return a;
  endfunction

  function automatic logic [2:0] cmd_permute(input logic [2:0] sel,
                                             input logic [2:0] cmd);
    logic [2:0] p;
    p = cmd;
    case (sel)
      3'd1: begin
        case (cmd)
          3'd0: p = 3'd0;
          3'd1: p = 3'd2;
          3'd2: p = 3'd6;
          3'd3: p = 3'd1;
          3'd4: p = 3'd7;
          3'd5: p = 3'd3;
          3'd6: p = 3'd4;
          default: p = 3'd5;
        endcase
      end
      3'd2: begin
        case (cmd)
          3'd0: p = 3'd0;
          3'd1: p = 3'd5;
          3'd2: p = 3'd4;
          3'd3: p = 3'd1;
          3'd4: p = 3'd7;
          3'd5: p = 3'd2;
          3'd6: p = 3'd6;
          default: p = 3'd3;
        endcase
      end
      3'd3: begin
        case (cmd)
          3'd0: p = 3'd0;
          3'd1: p = 3'd6;
          3'd2: p = 3'd3;
          3'd3: p = 3'd7;
          3'd4: p = 3'd5;
          3'd5: p = 3'd2;
          3'd6: p = 3'd4;
          default: p = 3'd1;
        endcase
      end
      3'd4: begin
        case (cmd)
          3'd0: p = 3'd0;
          3'd1: p = 3'd2;
          3'd2: p = 3'd5;
          3'd3: p = 3'd3;
          3'd4: p = 3'd6;
          3'd5: p = 3'd1;
          3'd6: p = 3'd7;
          default: p = 3'd4;
        endcase
      end
      default: p = cmd;
    endcase
    return p;
  endfunction

  function automatic logic [3:0] protect_nibble(input logic [2:0] sel,
                                                input logic [2:0] idx);
    logic [3:0] n;
    n = 4'h0;
    case ({sel, idx})
      {3'd1, 3'd6}: n = 4'h3;
      {3'd2, 3'd4}: n = 4'h3;
      {3'd2, 3'd5}: n = 4'h4;
      {3'd3, 3'd3}: n = 4'h1;
      {3'd3, 3'd5}: n = 4'h4;
      {3'd3, 3'd6}: n = 4'h5;
      {3'd7, 3'd3}: n = 4'h1;
      {3'd7, 3'd4}: n = 4'h2;
      {3'd7, 3'd5}: n = 4'h4;
      {3'd7, 3'd6}: n = 4'hF;
      default: n = 4'h0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: sv/cartridge_outer_bank_scrambler.sv
// Top level of the cartridge outer bank scrambler: outer registers, write
// scrambling, protection reads and PRG/CHR bank translation.
// Depends on cobs_pkg.
//
// Each request beat's result is computed from the input beat and the outer
// registers by table lookups and masking, and lands in a single output
// register. A new beat is taken every cycle while the output register is
// empty or being drained, so the block sustains one beat per clock. Outer
// register writes at 0x5000-0x5FFF take effect for the very next beat.
// Configuration registers sit at byte addresses 0, 4 and 8 of the APB port
// and should be written while no requests are in flight.
`default_nettype none

module cartridge_outer_bank_scrambler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // cpu_address[15:0], data_in[23:16], open_bus[31:24]
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // fwd_address[15:0], fwd_data[23:16],
                                       // read_data[31:24], bank_number[42:32], zero
  output logic [2:0]       out_tuser,  // fwd_valid[0], refresh_banks[1], read_valid[2]
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // Configuration registers
  logic       wide_submapper_r;
  logic       dip_enable_r;
  logic [7:0] dip_setting_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_submapper_r <= 1'b0;
      dip_enable_r     <= 1'b0;
      dip_setting_r    <= 8'h00;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        cobs_pkg::REG_WIDE_SUBMAPPER: wide_submapper_r <= cfg_pwdata[0];
        cobs_pkg::REG_DIP_ENABLE:     dip_enable_r     <= cfg_pwdata[0];
        cobs_pkg::REG_DIP_SETTING:    dip_setting_r    <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      cobs_pkg::REG_WIDE_SUBMAPPER: cfg_prdata = {31'h0, wide_submapper_r};
      cobs_pkg::REG_DIP_ENABLE:     cfg_prdata = {31'h0, dip_enable_r};
      cobs_pkg::REG_DIP_SETTING:    cfg_prdata = {24'h0, dip_setting_r};
      default:                      cfg_prdata = 32'h0;
    endcase
  end

  // Input beat fields
  cobs_pkg::req_type_t req_type;
  logic [15:0] cpu_address;
  logic [7:0]  data_in;
  logic [7:0]  open_bus;
  logic        in_fire;
  logic        outer_hit;

  assign req_type    = cobs_pkg::req_type_t'(in_tuser);
  assign cpu_address = in_tdata[15:0];
  assign data_in     = in_tdata[23:16];
  assign open_bus    = in_tdata[31:24];
  assign in_tready   = !out_tvalid || out_tready;
  assign in_fire     = in_tvalid && in_tready;
  assign outer_hit   = (cpu_address >= cobs_pkg::OUTER_LO) &&
                       (cpu_address <= cobs_pkg::OUTER_HI);

  // Outer registers
  logic [7:0] outer_mode_r;
  logic [7:0] outer_bank_r;
  logic [2:0] protect_sel_r;
  logic [2:0] scramble_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_mode_r   <= cobs_pkg::MODE_RESET;
      outer_bank_r   <= cobs_pkg::BANK_RESET;
      protect_sel_r  <= cobs_pkg::PROTECT_RESET;
      scramble_sel_r <= cobs_pkg::SCRAMBLE_RESET;
    end else if (in_fire && req_type == cobs_pkg::REQ_CPU_WRITE && outer_hit) begin
      case (cpu_address[2:0])
        cobs_pkg::OREG_MODE:     outer_mode_r   <= data_in;
        cobs_pkg::OREG_BANK:     outer_bank_r   <= data_in;
        cobs_pkg::OREG_PROTECT:  protect_sel_r  <= data_in[2:0];
        cobs_pkg::OREG_SCRAMBLE: scramble_sel_r <= data_in[2:0];
        default: ;
      endcase
    end
  end

  // Forwarded write
  logic [15:0] fwd_addr;
  logic [7:0]  fwd_data;

  always_comb begin
    fwd_addr = cobs_pkg::scramble_addr(scramble_sel_r,
                                       {cpu_address[14:13], cpu_address[0]});
    fwd_data = data_in;
    // Command writes keep bits 7-6, drop bits 5-3 and permute the index.
    if (fwd_addr == cobs_pkg::MMC3_CMD) begin
      fwd_data = {data_in[7:6], 3'b000,
                  cobs_pkg::cmd_permute(scramble_sel_r, data_in[2:0])};
    end
  end

  // PRG bank translation
  logic [7:0] prg_base;
  logic [7:0] prg_mask;
  logic [7:0] prg_val;
  logic [7:0] prg_bank;
  logic [1:0] slot;

  assign slot = cpu_address[14:13];

  always_comb begin
    prg_base = {1'b0, outer_bank_r[1:0], 5'b00000};
    prg_mask = outer_mode_r[6] ? 8'h0F : 8'h1F;
    prg_val  = data_in;
    if (wide_submapper_r) begin
      prg_base[7] = outer_bank_r[3];
    end
    if (dip_enable_r) begin
      if (dip_setting_r[0]) begin
        prg_base = prg_base & dip_setting_r;
      end else begin
        prg_base = prg_base | dip_setting_r;
      end
    end
    prg_base[4] = prg_base[4] | outer_bank_r[4];
    if (outer_mode_r[7]) begin
      if (outer_mode_r[5]) begin
        prg_base = prg_base & 8'hFC;
        prg_mask = prg_mask | 8'h03;
        prg_val  = {3'b000, outer_mode_r[3:1], slot};
      end else begin
        prg_base = prg_base & 8'hFE;
        prg_mask = prg_mask | 8'h01;
        prg_val  = {3'b000, outer_mode_r[3:0], slot[0]};
      end
    end
    prg_bank = (prg_base & ~prg_mask) | (prg_val & prg_mask);
  end

  // CHR bank translation
  logic [10:0] chr_base;
  logic [10:0] chr_mask;
  logic [10:0] chr_bank;

  always_comb begin
    chr_base = wide_submapper_r ? {outer_bank_r[3:1], 8'h00}
                                : {1'b0, outer_bank_r[3:2], 8'h00};
    chr_mask = outer_mode_r[6] ? 11'h07F : 11'h0FF;
    if (dip_enable_r && dip_setting_r[0]) begin
      chr_base = chr_base & {dip_setting_r, 3'b111};
    end
    chr_base[7] = chr_base[7] | outer_bank_r[5];
    chr_bank = (chr_base & ~chr_mask) | ({3'b000, data_in} & chr_mask);
  end

  // Result assembly
  cobs_pkg::res_flags_t flags_nxt;
  logic [15:0] fwd_address_nxt;
  logic [7:0]  fwd_data_nxt;
  logic [7:0]  read_data_nxt;
  logic [10:0] bank_number_nxt;

  always_comb begin
    flags_nxt       = '0;
    fwd_address_nxt = 16'h0000;
    fwd_data_nxt    = 8'h00;
    read_data_nxt   = 8'h00;
    bank_number_nxt = 11'h000;
    case (req_type)
      cobs_pkg::REQ_CPU_WRITE: begin
        if (outer_hit) begin
          flags_nxt.refresh_banks = (cpu_address[2:0] == cobs_pkg::OREG_MODE) ||
                                    (cpu_address[2:0] == cobs_pkg::OREG_BANK);
        end else if (cpu_address[15]) begin
          flags_nxt.fwd_valid = 1'b1;
          fwd_address_nxt     = fwd_addr;
          fwd_data_nxt        = fwd_data;
        end
      end
      cobs_pkg::REQ_CPU_READ: begin
        if (outer_hit) begin
          flags_nxt.read_valid = 1'b1;
          read_data_nxt = {open_bus[7:4],
                           cobs_pkg::protect_nibble(protect_sel_r, cpu_address[2:0])};
        end
      end
      cobs_pkg::REQ_PRG_XLATE: bank_number_nxt = {3'b000, prg_bank};
      cobs_pkg::REQ_CHR_XLATE: bank_number_nxt = chr_bank;
      default: ;
    endcase
  end

  // Output register
  logic                 out_valid_r;
  cobs_pkg::res_flags_t flags_r;
  logic [15:0]          fwd_address_r;
  logic [7:0]           fwd_data_r;
  logic [7:0]           read_data_r;
  logic [10:0]          bank_number_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      flags_r       <= flags_nxt;
      fwd_address_r <= fwd_address_nxt;
      fwd_data_r    <= fwd_data_nxt;
      read_data_r   <= read_data_nxt;
      bank_number_r <= bank_number_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = flags_r;
  assign out_tdata  = {5'b00000, bank_number_r, read_data_r, fwd_data_r, fwd_address_r};

endmodule

`default_nettype wire

FILE: sv/cobs_checker.sv
// Port-level checker for the cartridge outer bank scrambler, and the bind
// that attaches it to the top level. No package dependencies.
`default_nettype none

module cobs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic [2:0]  out_tuser
);

  // A stalled result beat must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_no_valid_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A beat carries at most one of forward, refresh and read.
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $countones(out_tuser) <= 1)
    else $error("more than one result flag set");

  // Forwarded writes only go to MMC3 registers 0x8000/0x8001 ... 0xE000/0xE001.
  a_fwd_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[15] && (out_tdata[12:1] == 12'h000))
    else $error("forwarded address outside MMC3 register set");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tdata[31:24] == 8'h00)
    else $error("read data set without a protection read");

endmodule

bind cartridge_outer_bank_scrambler cobs_checker u_cobs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
